/* design/cssr_pkg.sv */
package cssr_pkg;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int SIDE_REG_W  = 9;
	localparam int SCALE_W     = 16;
	localparam int COORD_W     = 16;
	localparam int COLOR_W     = 13;
	localparam int PIX_W       = 8;
	localparam int SUM_W       = 26;
	localparam int CNT_W       = 14;
	localparam int FRAC_SH     = 14;
	localparam int GEO_W       = 35;
	localparam int DIV_W       = 35;
	localparam int QUO_W       = 9;
	localparam int AVG_MUL     = 510;
	localparam int CNT_SH      = 12;
	localparam int DEN_SH      = 21;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

	localparam logic [SIDE_REG_W-1:0] WIDTH_RST  = 9'd200;
	localparam logic [SIDE_REG_W-1:0] HEIGHT_RST = 9'd200;
	localparam logic [SCALE_W-1:0]    SCALE_RST  = 16'd256;

	localparam logic [COORD_W:0]         RADIUS_GROW = 17'd32;
	localparam logic signed [GEO_W-1:0]  ROUND_UP    = 35'sd16383;
	localparam logic [7:0]               ALPHA_FULL  = 8'hFF;
	localparam logic [63:0]              ROOT_BIT0   = 64'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_SPLAT,
		CMD_RESOLVE,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		cmd_t               kind;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] radius;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [PIX_W-1:0]   pixel_col;
		logic [PIX_W-1:0]   pixel_row;
		logic               in_range;
	} job_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} entry_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_SPL_MUL,
		ST_SPL_RANGE,
		ST_ROW,
		ST_SQ,
		ST_ROOT_INIT,
		ST_SQRT,
		ST_SPAN,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_SUB_RD,
		ST_SUB_WR,
		ST_NEXT,
		ST_RES_RD,
		ST_RES_WR,
		ST_RD_RD,
		ST_RD_PREP,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic entry_t entry_add(entry_t e, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b, logic sub);
		entry_t o;
		if (sub) begin
			o.red   = e.red - SUM_W'(r);
			o.green = e.green - SUM_W'(g);
			o.blue  = e.blue - SUM_W'(b);
			o.cnt   = e.cnt - CNT_W'(1);
		end else begin
			o.red   = e.red + SUM_W'(r);
			o.green = e.green + SUM_W'(g);
			o.blue  = e.blue + SUM_W'(b);
			o.cnt   = e.cnt + CNT_W'(1);
		end
		return o;
	endfunction

	function automatic entry_t entry_sum(entry_t a, entry_t b);
		entry_t o;
		o.red   = a.red + b.red;
		o.green = a.green + b.green;
		o.blue  = a.blue + b.blue;
		o.cnt   = a.cnt + b.cnt;
		return o;
	endfunction

	function automatic logic [7:0] avg_byte(logic [QUO_W-1:0] q);
		logic [7:0] o;
		o = q[QUO_W-1] ? 8'hFF : q[7:0];
		return o;
	endfunction

endpackage

/* design/cssr_front.sv */
module cssr_front #(
	parameter int MAX_SIDE    = 256,
	parameter int MAX_CIRCLES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cssr_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic [$clog2(MAX_SIDE+1)-1:0]    side_w,
	input  logic [$clog2(MAX_SIDE+1)-1:0]    side_h,
	input  logic                             hold,
	output logic                             job_valid,
	input  logic                             job_ready,
	output cssr_pkg::job_t                   job
);
	import cssr_pkg::*;

	localparam int TW = $clog2(MAX_CIRCLES + 1);

	logic [TW-1:0] taken_q;
	job_t          q_mem [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	job_t          in_job;
	logic          accept;
	logic          push;
	logic          pop;
	logic          full;

	always_comb begin
		in_job.kind      = cmd_t'(s_tuser);
		in_job.center_x  = s_tdata[15:0];
		in_job.center_y  = s_tdata[31:16];
		in_job.radius    = s_tdata[47:32];
		in_job.red       = s_tdata[60:48];
		in_job.green     = s_tdata[73:61];
		in_job.blue      = s_tdata[86:74];
		in_job.pixel_col = s_tdata[94:87];
		in_job.pixel_row = s_tdata[102:95];
		in_job.in_range  = (32'(s_tdata[94:87]) < 32'(side_w)) &&
			(32'(s_tdata[102:95]) < 32'(side_h));
	end

	assign full      = (taken_q == TW'(MAX_CIRCLES));
	assign s_tready  = (cnt_q != 2'd2) && !hold;
	assign accept    = s_tvalid && s_tready;
	assign push      = accept && !((in_job.kind == CMD_SPLAT) && full);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_mem[rd_q];
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (accept && in_job.kind == CMD_CLEAR) begin
				taken_q <= '0;
			end else if (accept && in_job.kind == CMD_SPLAT && !full) begin
				taken_q <= taken_q + TW'(1);
			end
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= in_job;
		end
	end

endmodule

/* design/cssr_back.sv */
module cssr_back #(
	parameter int MAX_SIDE = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_SIDE+1)-1:0]     side_w,
	input  logic [$clog2(MAX_SIDE+1)-1:0]     side_h,
	input  logic [cssr_pkg::SCALE_W-1:0]      scale,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  cssr_pkg::job_t                    job,
	output logic                              init_busy,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cssr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                        m_tuser
);
	import cssr_pkg::*;

	localparam int XW = $clog2(MAX_SIDE);
	localparam int AW = 2 * XW;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [AW-1:0]     addr_q;
	logic              init_q;
	job_t              job_q;
	logic [31:0]       cx_q;
	logic [31:0]       cy_q;
	logic [31:0]       rs_q;
	logic [63:0]       rsq_q;
	logic [XW-1:0]     y_q;
	logic [XW-1:0]     y1_q;
	logic [XW-1:0]     xs_q;
	logic [XW-1:0]     xe_q;
	logic              sub_ok_q;
	logic [31:0]       ady_q;
	logic [63:0]       adysq_q;
	logic [63:0]       v_q;
	logic [63:0]       res_q;
	logic [63:0]       bit_q;
	entry_t            acc_q;
	logic [DIV_W-1:0]  num_q [3];
	logic [QUO_W-1:0]  quo_q [3];
	logic [DIV_W-1:0]  den_q;
	logic [3:0]        step_q;
	logic              cov_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic              out_cov_q;

	entry_t            mem [2**AW];
	entry_t            rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic              out_load;

	logic [COORD_W:0]        rad_g;
	logic [32:0]             rs_p;
	logic signed [GEO_W-1:0] y0_s;
	logic signed [GEO_W-1:0] y0c;
	logic signed [GEO_W-1:0] y1_s;
	logic signed [GEO_W-1:0] y1c;
	logic signed [GEO_W-1:0] hm_s;
	logic signed [GEO_W-1:0] wm_s;
	logic signed [GEO_W-1:0] dy_s;
	logic signed [GEO_W-1:0] ady_s;
	logic signed [GEO_W-1:0] xs_s;
	logic signed [GEO_W-1:0] xe_s;
	logic signed [GEO_W-1:0] xsc;
	logic signed [GEO_W-1:0] xec;
	logic [63:0]             trial;
	logic [XW-1:0]           xe1;
	logic [XW-1:0]           wm1x;
	logic [XW-1:0]           hm1x;
	logic                    cnt_pos;

	function automatic logic [DIV_W-1:0] lane_num(logic [SUM_W-1:0] s,
			logic [CNT_W-1:0] c);
		logic [DIV_W-1:0] n;
		if (s[SUM_W-1] || s == '0) begin
			n = '0;
		end else begin
			n = DIV_W'(s) * DIV_W'(AVG_MUL) + (DIV_W'(c) << CNT_SH);
		end
		return n;
	endfunction

	assign rad_g = (COORD_W+1)'(job_q.radius) + RADIUS_GROW;
	assign rs_p  = 33'(rad_g) * 33'(scale);
	assign hm_s  = $signed(GEO_W'(side_h)) - GEO_W'(1);
	assign wm_s  = $signed(GEO_W'(side_w)) - GEO_W'(1);
	assign y0_s  = ($signed(GEO_W'(cy_q)) - $signed(GEO_W'(rs_q)) + ROUND_UP) >>> FRAC_SH;
	assign y1_s  = ($signed(GEO_W'(cy_q)) + $signed(GEO_W'(rs_q))) >>> FRAC_SH;
	assign y0c   = (y0_s < 0) ? '0 : y0_s;
	assign y1c   = (y1_s > hm_s) ? hm_s : y1_s;
	assign dy_s  = $signed(GEO_W'(y_q) << FRAC_SH) - $signed(GEO_W'(cy_q));
	assign ady_s = (dy_s < 0) ? -dy_s : dy_s;
	assign xs_s  = ($signed(GEO_W'(cx_q)) - $signed(GEO_W'(res_q[31:0])) + ROUND_UP)
		>>> FRAC_SH;
	assign xe_s  = ($signed(GEO_W'(cx_q)) + $signed(GEO_W'(res_q[31:0]))) >>> FRAC_SH;
	assign xsc   = (xs_s < 0) ? '0 : xs_s;
	assign xec   = (xe_s > wm_s) ? wm_s : xe_s;
	assign trial = res_q + bit_q;
	assign xe1   = xe_q + XW'(1);
	assign wm1x  = XW'(side_w - 1'b1);
	assign hm1x  = XW'(side_h - 1'b1);
	assign cnt_pos = !rdata_q.cnt[CNT_W-1] && (rdata_q.cnt != '0);

	assign init_busy = init_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_cov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = {y_q, xs_q};
		mem_wdata = '0;
		mem_raddr = {y_q, xs_q};
		job_ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				if (&addr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					unique case (job.kind)
						CMD_CLEAR:   state_d = ST_CLR;
						CMD_SPLAT:   state_d = ST_SPL_MUL;
						CMD_RESOLVE: state_d = ST_RES_RD;
						CMD_READ:    state_d = job.in_range ? ST_RD_RD : ST_OUT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SPL_MUL:   state_d = ST_SPL_RANGE;
			ST_SPL_RANGE: state_d = (y0c > y1c) ? ST_IDLE : ST_ROW;
			ST_ROW:       state_d = (ady_s > $signed(GEO_W'(rs_q))) ? ST_NEXT : ST_SQ;
			ST_SQ:        state_d = ST_ROOT_INIT;
			ST_ROOT_INIT: state_d = ST_SQRT;
			ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN:      state_d = (xsc > xec) ? ST_NEXT : ST_ADD_RD;
			ST_ADD_RD:    state_d = ST_ADD_WR;
			ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = entry_add(rdata_q, job_q.red, job_q.green, job_q.blue, 1'b0);
				state_d   = sub_ok_q ? ST_SUB_RD : ST_NEXT;
			end
			ST_SUB_RD: begin
				mem_raddr = {y_q, xe1};
				state_d   = ST_SUB_WR;
			end
			ST_SUB_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {y_q, xe1};
				mem_wdata = entry_add(rdata_q, job_q.red, job_q.green, job_q.blue, 1'b1);
				state_d   = ST_NEXT;
			end
			ST_NEXT:      state_d = (y_q == y1_q) ? ST_IDLE : ST_ROW;
			ST_RES_RD:    state_d = ST_RES_WR;
			ST_RES_WR: begin
				mem_we    = (xs_q != '0);
				mem_wdata = entry_sum(acc_q, rdata_q);
				if (xs_q == wm1x && y_q == hm1x) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RES_RD;
				end
			end
			ST_RD_RD: begin
				mem_raddr = {XW'(job_q.pixel_row), XW'(job_q.pixel_col)};
				state_d   = ST_RD_PREP;
			end
			ST_RD_PREP:   state_d = cnt_pos ? ST_DIV : ST_OUT;
			ST_DIV: begin
				if (step_q == 4'(QUO_W - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLR) begin
				addr_q <= addr_q + AW'(1);
				if (&addr_q) begin
					init_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
				y_q   <= '0;
				xs_q  <= '0;
				cov_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					quo_q[i] <= '0;
				end
			end
			ST_SPL_MUL: begin
				cx_q <= 32'(job_q.center_x) * 32'(scale);
				cy_q <= 32'(job_q.center_y) * 32'(scale);
				rs_q <= rs_p[32] ? '1 : rs_p[31:0];
			end
			ST_SPL_RANGE: begin
				rsq_q <= 64'(rs_q) * 64'(rs_q);
				y_q   <= y0c[XW-1:0];
				y1_q  <= y1c[XW-1:0];
			end
			ST_ROW: begin
				ady_q <= ady_s[31:0];
			end
			ST_SQ: begin
				adysq_q <= 64'(ady_q) * 64'(ady_q);
			end
			ST_ROOT_INIT: begin
				v_q   <= rsq_q - adysq_q;
				res_q <= '0;
				bit_q <= ROOT_BIT0;
			end
			ST_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_SPAN: begin
				xs_q     <= xsc[XW-1:0];
				xe_q     <= xec[XW-1:0];
				sub_ok_q <= (xec < wm_s);
			end
			ST_NEXT: begin
				y_q <= y_q + XW'(1);
			end
			ST_RES_WR: begin
				acc_q <= (xs_q == '0) ? rdata_q : entry_sum(acc_q, rdata_q);
				if (xs_q == wm1x) begin
					xs_q <= '0;
					y_q  <= y_q + XW'(1);
				end else begin
					xs_q <= xs_q + XW'(1);
				end
			end
			ST_RD_PREP: begin
				cov_q    <= cnt_pos;
				num_q[0] <= lane_num(rdata_q.red, rdata_q.cnt);
				num_q[1] <= lane_num(rdata_q.green, rdata_q.cnt);
				num_q[2] <= lane_num(rdata_q.blue, rdata_q.cnt);
				den_q    <= DIV_W'(rdata_q.cnt) << DEN_SH;
				step_q   <= '0;
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (num_q[i] >= den_q) begin
						num_q[i] <= num_q[i] - den_q;
						quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
					end
				end
				den_q  <= den_q >> 1;
				step_q <= step_q + 4'd1;
			end
			ST_OUT: begin
				if (out_load) begin
					out_data_q <= {ALPHA_FULL, avg_byte(quo_q[2]), avg_byte(quo_q[1]),
						avg_byte(quo_q[0])};
					out_cov_q  <= cov_q;
				end
			end
			default: begin
			end
		endcase
	end

	// span store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

endmodule

/* design/circle_span_splat_renderer_unit.sv */
// Circle splat renderer. Command 0 clears the color-sum and cover-count store,
// 1 splats a circle as per-row span ends, 2 turns each row of the canvas into
// running sums, 3 reads one pixel as an averaged RGBA byte quad (covered flag
// on m_tuser) and is the only command that gives a result transfer. After
// reset, and for every clear, the store is swept one entry a cycle; input is
// held off during the sweep that follows reset. A splat works row by row over
// its span: the square root resolves one result bit a cycle and each span end
// is a read-modify-write on the store. A resolve reads and then writes each
// pixel in use; a read averages through the nine-step restoring divider. A
// two-entry queue lets commands arrive while earlier ones are still being
// worked off.
module circle_span_splat_renderer_unit #(
	parameter int MAX_SIDE    = 256,
	parameter int MAX_CIRCLES = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// center_x, center_y, radius, red_in, green_in, blue_in, pixel_col, pixel_row
	input  logic [cssr_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// red_out, green_out, blue_out, alpha_out
	output logic [cssr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// covered
	output logic [0:0]                        m_tuser,
	input  logic                              cfg_write,
	input  logic [cssr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cssr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cssr_pkg::*;

	localparam int SW = $clog2(MAX_SIDE + 1);

	logic [SIDE_REG_W-1:0] width_q;
	logic [SIDE_REG_W-1:0] height_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [31:0]           w_full;
	logic [31:0]           h_full;
	logic [SW-1:0]         side_w;
	logic [SW-1:0]         side_h;
	logic                  hold;
	logic                  job_valid;
	logic                  job_ready;
	job_t                  job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[SIDE_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIDE_REG_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign w_full = (width_q == '0) ? 32'd1 :
		((32'(width_q) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(width_q));
	assign h_full = (height_q == '0) ? 32'd1 :
		((32'(height_q) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(height_q));
	assign side_w = w_full[SW-1:0];
	assign side_h = h_full[SW-1:0];

	cssr_front #(
		.MAX_SIDE    (MAX_SIDE),
		.MAX_CIRCLES (MAX_CIRCLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.side_w    (side_w),
		.side_h    (side_h),
		.hold      (hold),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	cssr_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.side_w    (side_w),
		.side_h    (side_h),
		.scale     (scale_q),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.init_busy (hold),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* design/cssr_checker.sv */
module cssr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cssr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [0:0]                        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:24] == 8'hFF)
		else $error("alpha not opaque");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'h0)
		else $error("uncovered pixel not black");

endmodule

bind circle_span_splat_renderer_unit cssr_checker u_cssr_checker (.*);
